### design/ntsc_ss_pkg.sv
package ntsc_ss_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register field widths
  localparam int VIS_LINES_W  = 9;
  localparam int LINE_BYTES_W = 8;
  localparam int VOFFSET_W    = 8;
  localparam int TOTAL_W      = 10;
  localparam int BASE_W       = 16;

  // Result field widths
  localparam int LINE_ADDR_W  = 16;
  localparam int SYNC_W       = 11;
  localparam int LINE_NUM_W   = 10;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VISIBLE_LINES   = 3'd0,
    REG_LINE_BYTES      = 3'd1,
    REG_HALF_MODE       = 3'd2,
    REG_VERTICAL_OFFSET = 3'd3,
    REG_TOTAL_LINES     = 3'd4,
    REG_FRAME_BASE      = 3'd5
  } cfg_reg_e;

  // Reset values of the registers
  localparam logic [VIS_LINES_W-1:0]  VISIBLE_LINES_RST   = 9'd216;
  localparam logic [LINE_BYTES_W-1:0] LINE_BYTES_RST      = 8'd28;
  localparam logic                    HALF_MODE_RST       = 1'b1;
  localparam logic [VOFFSET_W-1:0]    VERTICAL_OFFSET_RST = 8'd0;
  localparam logic [TOTAL_W-1:0]      TOTAL_LINES_RST     = 10'd262;
  localparam logic [BASE_W-1:0]       FRAME_BASE_RST      = 16'd0;

  // Frame geometry
  localparam int VIS_TOP     = 30;
  localparam int VSYNC_FIRST = 2;
  localparam int VSYNC_LAST  = 4;

  localparam logic [SYNC_W-1:0] SYNC_LONG  = 11'd1412;
  localparam logic [SYNC_W-1:0] SYNC_SHORT = 11'd112;

  typedef struct packed {
    logic [VIS_LINES_W-1:0]  visible_lines;
    logic [LINE_BYTES_W-1:0] line_bytes;
    logic                    half_mode;
    logic [VOFFSET_W-1:0]    vertical_offset;
    logic [TOTAL_W-1:0]      total_lines;
    logic [BASE_W-1:0]       frame_base;
  } cfg_t;

  typedef struct packed {
    logic                   line_active;
    logic [LINE_ADDR_W-1:0] line_address;
    logic                   long_sync;
    logic [SYNC_W-1:0]      sync_width;
    logic [LINE_NUM_W-1:0]  line_number;
    logic                   frame_wrap;
  } result_t;

endpackage

### design/ntsc_ss_if.sv
interface ntsc_ss_in_if;
  logic valid;
  logic ready;
  logic line_tick;

  modport source (output valid, output line_tick, input ready);
  modport sink   (input valid, input line_tick, output ready);
endinterface

interface ntsc_ss_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  line_active;
  logic [ntsc_ss_pkg::LINE_ADDR_W-1:0]   line_address;
  logic                                  long_sync;
  logic [ntsc_ss_pkg::SYNC_W-1:0]        sync_width;
  logic [ntsc_ss_pkg::LINE_NUM_W-1:0]    line_number;
  logic                                  frame_wrap;

  modport source (
    output valid, output line_active, output line_address, output long_sync,
    output sync_width, output line_number, output frame_wrap, input ready
  );
  modport sink (
    input valid, input line_active, input line_address, input long_sync,
    input sync_width, input line_number, input frame_wrap, output ready
  );
endinterface

### design/ntsc_scanline_sequencer_top.sv
// Path: an accepted tick word passes the input register, then the result register,
//   to become its result word; a word with line_tick low is dropped and yields no result.
// Throughput: one tick word per cycle while the result register is empty or being drained.
// Reset (rst_ni low, asynchronous): line counter to 1, read address to 0, registers to
//   their defaults, both pipeline stages empty.
module ntsc_scanline_sequencer_top #(
  parameter int ADDR_WIDTH       = 16,
  parameter int LINE_COUNT_WIDTH = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // register write port
  input  logic                                 cfg_we_i,
  input  logic [ntsc_ss_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [ntsc_ss_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // tick words in, line result words out
  ntsc_ss_in_if.sink                           in_i,
  ntsc_ss_out_if.source                        out_o
);

  ntsc_ss_pkg::cfg_t    cfg;
  ntsc_ss_pkg::result_t res;
  logic                 res_valid;
  logic                 out_space;

  // Hold the six control registers; new values apply to the next tick.
  ntsc_ss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Register the tick, evaluate the window and sync checks against the line
  // counter, and advance counter and address when the result word moves on.
  ntsc_ss_core #(
    .ADDR_WIDTH       (ADDR_WIDTH),
    .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .out_space_i (out_space),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the result word until the sink takes it; the input stage keeps
  // flowing whenever this register is empty or being drained.
  ntsc_ss_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_space_o (out_space),
    .out_o       (out_o)
  );

endmodule

### design/ntsc_ss_cfg.sv
module ntsc_ss_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ntsc_ss_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [ntsc_ss_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output ntsc_ss_pkg::cfg_t                    cfg_o
);

  ntsc_ss_pkg::cfg_t cfg_q;
  ntsc_ss_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ntsc_ss_pkg::cfg_reg_e'(cfg_index_i))
        ntsc_ss_pkg::REG_VISIBLE_LINES:
          cfg_d.visible_lines = cfg_wdata_i[ntsc_ss_pkg::VIS_LINES_W-1:0];
        ntsc_ss_pkg::REG_LINE_BYTES:
          cfg_d.line_bytes = cfg_wdata_i[ntsc_ss_pkg::LINE_BYTES_W-1:0];
        ntsc_ss_pkg::REG_HALF_MODE:
          cfg_d.half_mode = cfg_wdata_i[0];
        ntsc_ss_pkg::REG_VERTICAL_OFFSET:
          cfg_d.vertical_offset = cfg_wdata_i[ntsc_ss_pkg::VOFFSET_W-1:0];
        ntsc_ss_pkg::REG_TOTAL_LINES:
          cfg_d.total_lines = cfg_wdata_i[ntsc_ss_pkg::TOTAL_W-1:0];
        ntsc_ss_pkg::REG_FRAME_BASE:
          cfg_d.frame_base = cfg_wdata_i[ntsc_ss_pkg::BASE_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.visible_lines   <= ntsc_ss_pkg::VISIBLE_LINES_RST;
      cfg_q.line_bytes      <= ntsc_ss_pkg::LINE_BYTES_RST;
      cfg_q.half_mode       <= ntsc_ss_pkg::HALF_MODE_RST;
      cfg_q.vertical_offset <= ntsc_ss_pkg::VERTICAL_OFFSET_RST;
      cfg_q.total_lines     <= ntsc_ss_pkg::TOTAL_LINES_RST;
      cfg_q.frame_base      <= ntsc_ss_pkg::FRAME_BASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/ntsc_ss_core.sv
module ntsc_ss_core #(
  parameter int ADDR_WIDTH       = 16,
  parameter int LINE_COUNT_WIDTH = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ntsc_ss_in_if.sink           in_i,
  input  ntsc_ss_pkg::cfg_t    cfg_i,
  input  logic                 out_space_i,
  output logic                 res_valid_o,
  output ntsc_ss_pkg::result_t res_o
);

  localparam int CmpW     = (LINE_COUNT_WIDTH + 1 > 11) ? LINE_COUNT_WIDTH + 1 : 11;
  localparam int AddrOutW = ntsc_ss_pkg::LINE_ADDR_W;
  localparam int NumOutW  = ntsc_ss_pkg::LINE_NUM_W;

  // Input stage
  logic s1_valid_q, s1_valid_d;
  logic s1_tick_q;
  logic s1_free;
  logic fire;
  logic drop;

  // Scan state
  logic [LINE_COUNT_WIDTH-1:0] line_cnt_q, line_cnt_d;
  logic [ADDR_WIDTH-1:0]       read_addr_q, read_addr_d;

  logic [CmpW-1:0] line_c, start_c, stop_c, next_c, total_c;
  logic            active, long_sync, wrap, step;

  assign fire    = s1_valid_q && s1_tick_q && out_space_i;
  assign drop    = s1_valid_q && !s1_tick_q;
  assign s1_free = !s1_valid_q || !s1_tick_q || out_space_i;
  assign in_i.ready = s1_free;
  assign s1_valid_d = (in_i.valid && s1_free) || (s1_valid_q && !s1_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_free) begin
      s1_tick_q <= in_i.line_tick;
    end
  end

  always_comb begin
    line_c  = CmpW'(line_cnt_q);
    start_c = CmpW'(ntsc_ss_pkg::VIS_TOP) + CmpW'(cfg_i.vertical_offset);
    stop_c  = start_c + CmpW'(cfg_i.visible_lines);
    next_c  = line_c + CmpW'(1);
    total_c = CmpW'(cfg_i.total_lines);

    active    = (line_c >= start_c) && (line_c < stop_c);
    long_sync = (line_c >= CmpW'(ntsc_ss_pkg::VSYNC_FIRST)) &&
                (line_c <= CmpW'(ntsc_ss_pkg::VSYNC_LAST));
    // step on odd lines; this matches odd (line - top) only when VIS_TOP plus vertical_offset is even
    step      = active && (!cfg_i.half_mode || line_cnt_q[0]);
    wrap      = (next_c > total_c) || next_c[LINE_COUNT_WIDTH];

    line_cnt_d  = line_cnt_q;
    read_addr_d = read_addr_q;
    if (fire) begin
      if (wrap) begin
        line_cnt_d  = LINE_COUNT_WIDTH'(1);
        read_addr_d = ADDR_WIDTH'(cfg_i.frame_base);
      end else begin
        line_cnt_d = next_c[LINE_COUNT_WIDTH-1:0];
        if (step) begin
          read_addr_d = read_addr_q + ADDR_WIDTH'(cfg_i.line_bytes);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q  <= LINE_COUNT_WIDTH'(1);
      read_addr_q <= '0;
    end else begin
      line_cnt_q  <= line_cnt_d;
      read_addr_q <= read_addr_d;
    end
  end

  always_comb begin
    res_o.line_active  = active;
    res_o.line_address = active ? AddrOutW'(read_addr_q) : '0;
    res_o.long_sync    = long_sync;
    res_o.sync_width   = long_sync ? ntsc_ss_pkg::SYNC_LONG : ntsc_ss_pkg::SYNC_SHORT;
    res_o.line_number  = NumOutW'(line_cnt_q);
    res_o.frame_wrap   = wrap;
  end

  assign res_valid_o = fire;

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_cnt_q != '0)
    else $error("line counter reached zero");

  a_wrap_to_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && wrap |=> line_cnt_q == LINE_COUNT_WIDTH'(1))
    else $error("frame wrap did not return counter to line one");

  a_idle_addr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !active && !wrap |=> $stable(read_addr_q))
    else $error("read address moved on an inactive line");

  a_drop_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |=> $stable(line_cnt_q) && $stable(read_addr_q))
    else $error("low tick changed the scan state");

endmodule

### design/ntsc_ss_out.sv
module ntsc_ss_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  ntsc_ss_pkg::result_t res_i,
  output logic                 out_space_o,
  ntsc_ss_out_if.source        out_o
);

  logic                 out_valid_q, out_valid_d;
  ntsc_ss_pkg::result_t res_q;

  assign out_space_o = !out_valid_q || out_o.ready;
  assign out_valid_d = res_valid_i || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.line_active  = res_q.line_active;
  assign out_o.line_address = res_q.line_address;
  assign out_o.long_sync    = res_q.long_sync;
  assign out_o.sync_width   = res_q.sync_width;
  assign out_o.line_number  = res_q.line_number;
  assign out_o.frame_wrap   = res_q.frame_wrap;

endmodule
